// ===== rtl/bsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants of the bmp stream parser: transfer payloads,
// status codes, header layout and the frame geometry passed between units.
// ----------------------------------------------------------------------------
package bsp_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int USED_W = WID_W + 2;

    // header layout
    localparam logic [5:0]  HDR_LAST = 6'd53;
    localparam logic [31:0] HDR_LEN  = 32'd54;
    localparam logic [7:0]  SIG_B    = 8'h42;
    localparam logic [7:0]  SIG_M    = 8'h4D;
    localparam logic [15:0] BPP_24   = 16'd24;
    localparam logic [15:0] BPP_32   = 16'd32;

    // frame status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT_HDR = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_BAD_GEOM  = 3'd3;
    localparam logic [2:0] ST_BAD_OFF   = 3'd4;
    localparam logic [2:0] ST_TRUNC     = 3'd5;
    localparam logic [2:0] ST_TOO_LARGE = 3'd6;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       end_of_file;
    } t_in_item;

    typedef struct packed {
        logic        pixel_valid;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_done;
        logic [2:0]  status;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_out_item;

    // header check, valid on the last header byte
    typedef struct packed {
        logic [2:0]       err;
        logic [WID_W-1:0] width;
        logic [HGT_W-1:0] hmag;
    } t_check;

    // geometry of an accepted frame
    typedef struct packed {
        logic [31:0]       offset;
        logic [WID_W-1:0]  width;
        logic [HGT_W-1:0]  hmag;
        logic              bpb4;
        logic              bottom_up;
        logic [USED_W-1:0] used;
        logic [USED_W-1:0] rowsize;
    } t_geom;

    typedef struct packed {
        logic             valid;
        logic [7:0]       blue;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [WID_W-1:0] column;
        logic [HGT_W-1:0] row;
        logic             last;
    } t_pixel;

endpackage
`default_nettype wire

// ===== rtl/bsp_hdr.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_hdr
// Captures the little-endian header fields, checks them and holds the
// frame geometry for the pixel unpacker.
// ----------------------------------------------------------------------------
module bsp_hdr (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_capture,
    input  wire logic           i_clear,
    input  wire logic [5:0]     i_idx,
    input  wire logic [7:0]     i_byte,
    output bsp_pkg::t_check     o_check,
    output bsp_pkg::t_geom      o_geom
);

    logic [31:0] r_off;
    logic [31:0] r_width;
    logic [31:0] r_height;
    logic [15:0] r_bpp;

    logic [bsp_pkg::WID_W-1:0]  r_g_width;
    logic [bsp_pkg::HGT_W-1:0]  r_g_hmag;
    logic                       r_g_bpb4;
    logic                       r_g_bottom_up;
    logic [bsp_pkg::USED_W-1:0] r_g_used;
    logic [bsp_pkg::USED_W-1:0] r_g_rowsize;

    logic [31:0]                hmag32;
    logic                       bpp_ok;
    logic                       bpb4;
    logic [2:0]                 err;
    logic [bsp_pkg::WID_W-1:0]  w_n;
    logic [bsp_pkg::USED_W-1:0] used_c;
    logic [bsp_pkg::USED_W-1:0] rowsize_c;
    logic [1:0]                 lane_off;
    logic [1:0]                 lane_wid;
    logic [1:0]                 lane_hgt;
    logic                       lane_bpp;

    always_comb begin
        hmag32 = r_height[31] ? (32'd0 - r_height) : r_height;
        bpp_ok = (r_bpp == bsp_pkg::BPP_24) || (r_bpp == bsp_pkg::BPP_32);
        bpb4   = (r_bpp == bsp_pkg::BPP_32);
        if (r_width[31] || r_width == 32'd0 || r_height == 32'd0 || !bpp_ok) begin
            err = bsp_pkg::ST_BAD_GEOM;
        end else if (r_off[31] || r_off < bsp_pkg::HDR_LEN) begin
            err = bsp_pkg::ST_BAD_OFF;
        end else if (r_width > 32'(bsp_pkg::MAX_WIDTH)
                     || hmag32 > 32'(bsp_pkg::MAX_HEIGHT)) begin
            err = bsp_pkg::ST_TOO_LARGE;
        end else begin
            err = bsp_pkg::ST_OK;
        end

        // bytes of a row holding pixels, then padded to a 4-byte multiple
        w_n    = r_width[bsp_pkg::WID_W-1:0];
        used_c = bpb4 ? {w_n, 2'b00}
                      : ({2'b00, w_n} + {1'b0, w_n, 1'b0});
        rowsize_c = (used_c + bsp_pkg::USED_W'(3)) & ~bsp_pkg::USED_W'(3);

        o_check.err   = err;
        o_check.width = w_n;
        o_check.hmag  = hmag32[bsp_pkg::HGT_W-1:0];

        lane_off = 2'(i_idx - 6'd10);
        lane_wid = 2'(i_idx - 6'd18);
        lane_hgt = 2'(i_idx - 6'd22);
        lane_bpp = i_idx[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_off    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_bpp    <= '0;
        end else if (i_capture) begin
            case (i_idx) inside
                [6'd10:6'd13]: r_off[{lane_off, 3'b000} +: 8]    <= i_byte;
                [6'd18:6'd21]: r_width[{lane_wid, 3'b000} +: 8]  <= i_byte;
                [6'd22:6'd25]: r_height[{lane_hgt, 3'b000} +: 8] <= i_byte;
                [6'd28:6'd29]: r_bpp[{lane_bpp, 3'b000} +: 8]    <= i_byte;
                default: begin
                end
            endcase
        end
    end

    // geometry is frozen once the header is complete
    always_ff @(posedge i_clk) begin
        if (i_capture && i_idx == bsp_pkg::HDR_LAST) begin
            r_g_width     <= w_n;
            r_g_hmag      <= hmag32[bsp_pkg::HGT_W-1:0];
            r_g_bpb4      <= bpb4;
            r_g_bottom_up <= !r_height[31];
            r_g_used      <= used_c;
            r_g_rowsize   <= rowsize_c;
        end
    end

    assign o_geom.offset    = r_off;
    assign o_geom.width     = r_g_width;
    assign o_geom.hmag      = r_g_hmag;
    assign o_geom.bpb4      = r_g_bpb4;
    assign o_geom.bottom_up = r_g_bottom_up;
    assign o_geom.used      = r_g_used;
    assign o_geom.rowsize   = r_g_rowsize;

endmodule
`default_nettype wire

// ===== rtl/bsp_pix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pix
// Unpacks pixel data bytes into B,G,R pixels, skipping alpha and row
// padding, and tracks the destination column and row.
// ----------------------------------------------------------------------------
module bsp_pix (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire logic          i_clear,
    input  wire logic [7:0]    i_byte,
    input  wire bsp_pkg::t_geom i_geom,
    output bsp_pkg::t_pixel    o_pixel
);

    logic [bsp_pkg::USED_W-1:0] r_k;
    logic [1:0]                 r_comp;
    logic [bsp_pkg::WID_W-1:0]  r_col;
    logic [bsp_pkg::HGT_W-1:0]  r_row;
    logic [15:0]                r_held;

    logic                       in_data;
    logic                       last_comp;
    logic [bsp_pkg::WID_W-1:0]  col_inc;
    logic [bsp_pkg::HGT_W-1:0]  row_inc;
    logic [bsp_pkg::USED_W-1:0] k_inc;
    logic                       row_end;

    always_comb begin
        in_data   = r_k < i_geom.used;
        last_comp = i_geom.bpb4 ? (r_comp == 2'd3) : (r_comp == 2'd2);
        col_inc   = r_col + bsp_pkg::WID_W'(1);
        row_inc   = r_row + bsp_pkg::HGT_W'(1);
        k_inc     = r_k + bsp_pkg::USED_W'(1);
        row_end   = k_inc >= i_geom.rowsize;

        o_pixel.valid  = i_step && in_data && r_comp == 2'd2;
        o_pixel.blue   = r_held[7:0];
        o_pixel.green  = r_held[15:8];
        o_pixel.red    = i_byte;
        o_pixel.column = r_col;
        // bottom-up files store the last display row first
        o_pixel.row    = i_geom.bottom_up ? (i_geom.hmag - row_inc) : r_row;
        o_pixel.last   = i_step && in_data && last_comp
                         && col_inc == i_geom.width && row_inc == i_geom.hmag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_k    <= '0;
            r_comp <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_step) begin
            if (in_data) begin
                if (last_comp) begin
                    r_col  <= col_inc;
                    r_comp <= '0;
                end else begin
                    r_comp <= r_comp + 2'd1;
                end
            end
            if (row_end) begin
                r_k    <= '0;
                r_col  <= '0;
                r_row  <= row_inc;
                r_comp <= '0;
            end else begin
                r_k <= k_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && in_data) begin
            if (r_comp == 2'd0) begin
                r_held <= {8'd0, i_byte};
            end else if (r_comp == 2'd1) begin
                r_held[15:8] <= i_byte;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/bmp_stream_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_stream_parser
// Parses a 24 or 32 bit BMP byte stream into B,G,R pixels with destination
// coordinates, and reports status and dimensions on the final byte.
// ----------------------------------------------------------------------------
// One file byte is taken per cycle while the output is not stalled, whatever
// the byte produces. A byte is registered in the input register, then the
// header unit and pixel unpacker act on it and any result lands in the
// output register, from which it is shown on o_out_item. Bytes that produce
// nothing (header, offset gap, alpha, padding) still pass through the input
// register. The input stalls only while the output register holds an
// untaken result. After the byte marked end_of_file the parser is back in
// its reset state, ready for the next file on the following byte.
// ----------------------------------------------------------------------------
module bmp_stream_parser (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output      logic           o_in_ready,
    input  wire bsp_pkg::t_in_item i_in_item,
    output      logic           o_out_valid,
    input  wire logic           i_out_ready,
    output bsp_pkg::t_out_item  o_out_item
);

    localparam logic [1:0] PH_HEADER   = 2'd0;
    localparam logic [1:0] PH_SKIP     = 2'd1;
    localparam logic [1:0] PH_PIXELS   = 2'd2;
    localparam logic [1:0] PH_FINISHED = 2'd3;

    logic               r_in_valid;
    bsp_pkg::t_in_item  r_in;
    logic               r_out_valid;
    bsp_pkg::t_out_item r_out;
    logic [1:0]         r_phase;
    logic [31:0]        r_pos;
    logic [2:0]         r_err;

    logic               adv;
    logic               hdr_capture;
    logic               hdr_check;
    logic               pix_step;
    logic               clear;
    logic [1:0]         n_phase;
    logic [2:0]         n_err;
    logic               has_result;
    bsp_pkg::t_out_item res;
    bsp_pkg::t_check    chk;
    bsp_pkg::t_geom     geom;
    bsp_pkg::t_pixel    pix;

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // the byte at the offset is already the first pixel byte
    assign pix_step = adv && ((r_phase == PH_PIXELS)
                              || (r_phase == PH_SKIP && r_pos == geom.offset));

    bsp_hdr u_hdr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_capture (hdr_capture),
        .i_clear   (clear),
        .i_idx     (r_pos[5:0]),
        .i_byte    (r_in.file_byte),
        .o_check   (chk),
        .o_geom    (geom)
    );

    bsp_pix u_pix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (pix_step),
        .i_clear (clear),
        .i_byte  (r_in.file_byte),
        .i_geom  (geom),
        .o_pixel (pix)
    );

    always_comb begin
        hdr_capture = 1'b0;
        hdr_check   = 1'b0;
        n_phase     = r_phase;
        n_err       = r_err;
        clear       = adv && r_in.end_of_file;

        case (r_phase)
            PH_HEADER: begin
                if ((r_pos == 32'd0 && r_in.file_byte != bsp_pkg::SIG_B)
                    || (r_pos == 32'd1 && r_in.file_byte != bsp_pkg::SIG_M)) begin
                    n_err   = bsp_pkg::ST_BAD_SIG;
                    n_phase = PH_FINISHED;
                end else begin
                    hdr_capture = adv;
                    if (r_pos[5:0] == bsp_pkg::HDR_LAST) begin
                        hdr_check = 1'b1;
                        n_err     = chk.err;
                        n_phase   = (chk.err != bsp_pkg::ST_OK) ? PH_FINISHED : PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (r_pos == geom.offset) begin
                    n_phase = PH_PIXELS;
                end
            end
            default: begin
            end
        endcase

        if (pix.last) begin
            n_phase = PH_FINISHED;
        end

        res = '0;
        if (pix.valid) begin
            res.pixel_valid = 1'b1;
            res.blue        = pix.blue;
            res.green       = pix.green;
            res.red         = pix.red;
            res.column      = pix.column[11:0];
            res.row         = pix.row[11:0];
        end
        if (r_in.end_of_file) begin
            res.frame_done = 1'b1;
            if (n_err != bsp_pkg::ST_OK) begin
                res.status = n_err;
            end else begin
                case (n_phase)
                    PH_HEADER: res.status = bsp_pkg::ST_SHORT_HDR;
                    PH_SKIP:   res.status = bsp_pkg::ST_BAD_OFF;
                    PH_PIXELS: res.status = bsp_pkg::ST_TRUNC;
                    default:   res.status = bsp_pkg::ST_OK;
                endcase
            end
            if (n_phase != PH_HEADER && n_err == bsp_pkg::ST_OK) begin
                res.image_width  = 13'(hdr_check ? chk.width : geom.width);
                res.image_height = 13'(hdr_check ? chk.hmag : geom.hmag);
            end
        end
        has_result = pix.valid || r_in.end_of_file;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clear) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_err   <= bsp_pkg::ST_OK;
        end else if (adv) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            if (r_pos != 32'hFFFF_FFFF) begin
                r_pos <= r_pos + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload is loaded only with a new transfer
    always_ff @(posedge i_clk) begin
        if (adv && has_result) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

// ===== tb/tb_bmp_stream_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bmp_stream_parser
// Streams whole and broken BMP files through the parser byte by byte, with
// random gaps on the input and random stalls on the output. A byte-level
// model of the parser predicts every pixel and frame report, and each result
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bmp_stream_parser;
    import bsp_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_DONE
    } t_parse_phase;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    t_in_item  file_bytes_q [$];
    t_out_item expected_q [$];
    logic      in_fire    = 1'b0;
    int        mismatches = 0;
    int        cycle_cnt  = 0;

    // no idling in either direction during this window
    wire quiet = (cycle_cnt >= 600) && (cycle_cnt < 1100);

    // parser model state
    logic [31:0]  pos_cnt;
    logic [31:0]  hdr_width;
    logic [31:0]  hdr_height;
    logic [31:0]  hdr_offset;
    logic [15:0]  hdr_bpp;
    logic [31:0]  col_cnt;
    logic [31:0]  row_cnt;
    logic [31:0]  row_bytes;
    logic [15:0]  held_bg;
    logic [2:0]   err_code;
    t_parse_phase phase;

    bmp_stream_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    always #5 i_clk = ~i_clk;

    function automatic void clear_parser();
        pos_cnt    = '0;
        hdr_width  = '0;
        hdr_height = '0;
        hdr_offset = '0;
        hdr_bpp    = '0;
        col_cnt    = '0;
        row_cnt    = '0;
        row_bytes  = '0;
        held_bg    = '0;
        err_code   = ST_OK;
        phase      = PH_HEADER;
    endfunction

    function automatic logic [31:0] height_mag();
        return hdr_height[31] ? (32'd0 - hdr_height) : hdr_height;
    endfunction

    // advances the model by one file byte, returns 1 when a result is due
    function automatic bit parse_byte(input t_in_item it, output t_out_item res);
        logic [31:0] b;
        logic [31:0] pos;
        logic [31:0] bpb;
        logic [31:0] used;
        logic [31:0] rowsize;
        logic [31:0] k;
        logic [31:0] comp;
        logic [31:0] dest_row;
        logic [31:0] hmag;
        b   = {24'd0, it.file_byte};
        pos = pos_cnt;
        res = '0;

        if (phase == PH_HEADER) begin
            if ((pos == 0 && it.file_byte != SIG_B) || (pos == 1 && it.file_byte != SIG_M)) begin
                err_code = ST_BAD_SIG;
                phase    = PH_DONE;
            end else begin
                if (pos >= 10 && pos <= 13) hdr_offset |= b << (8 * (pos - 10));
                if (pos >= 18 && pos <= 21) hdr_width  |= b << (8 * (pos - 18));
                if (pos >= 22 && pos <= 25) hdr_height |= b << (8 * (pos - 22));
                if (pos >= 28 && pos <= 29) hdr_bpp    |= 16'(b << (8 * (pos - 28)));
                if (pos == HDR_LEN - 1) begin
                    if (hdr_width[31] || hdr_width == 0 || hdr_height == 0 ||
                        (hdr_bpp != BPP_24 && hdr_bpp != BPP_32))
                        err_code = ST_BAD_GEOM;
                    else if (hdr_offset[31] || hdr_offset < HDR_LEN)
                        err_code = ST_BAD_OFF;
                    else if (hdr_width > MAX_WIDTH || height_mag() > MAX_HEIGHT)
                        err_code = ST_TOO_LARGE;
                    phase = (err_code != ST_OK) ? PH_DONE : PH_SKIP;
                end
            end
        end else if (phase == PH_SKIP) begin
            if (pos == hdr_offset) phase = PH_PIXELS;
        end

        if (phase == PH_PIXELS && pos >= hdr_offset) begin
            bpb     = {16'd0, hdr_bpp} / 8;
            used    = hdr_width * bpb;
            rowsize = (used + 3) & ~32'd3;
            k       = row_bytes;
            if (k < used) begin
                comp = k - col_cnt * bpb;
                if (comp == 0) begin
                    held_bg = {8'd0, it.file_byte};
                end else if (comp == 1) begin
                    held_bg = {it.file_byte, held_bg[7:0]};
                end else if (comp == 2) begin
                    dest_row        = hdr_height[31] ? row_cnt : (height_mag() - 1 - row_cnt);
                    res.pixel_valid = 1'b1;
                    res.blue        = held_bg[7:0];
                    res.green       = held_bg[15:8];
                    res.red         = it.file_byte;
                    res.column      = col_cnt[11:0];
                    res.row         = dest_row[11:0];
                end
                if (comp == bpb - 1) begin
                    col_cnt = col_cnt + 1;
                    if (col_cnt == hdr_width && row_cnt + 1 == height_mag()) phase = PH_DONE;
                end
            end
            k = k + 1;
            if (k >= rowsize) begin
                k       = 0;
                col_cnt = 0;
                row_cnt = row_cnt + 1;
            end
            row_bytes = k;
        end

        if (pos_cnt != 32'hFFFF_FFFF) pos_cnt = pos_cnt + 1;

        if (it.end_of_file) begin
            res.frame_done = 1'b1;
            if (err_code != ST_OK)       res.status = err_code;
            else if (phase == PH_HEADER) res.status = ST_SHORT_HDR;
            else if (phase == PH_SKIP)   res.status = ST_BAD_OFF;
            else if (phase == PH_PIXELS) res.status = ST_TRUNC;
            else                         res.status = ST_OK;
            if (phase != PH_HEADER && err_code == ST_OK) begin
                hmag             = height_mag();
                res.image_width  = hdr_width[12:0];
                res.image_height = hmag[12:0];
            end
            clear_parser();
        end
        return res.pixel_valid || it.end_of_file;
    endfunction

    // one file of len bytes: the header fields given, everything else random
    task automatic add_file(input logic [7:0] s0, input logic [7:0] s1,
                            input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] off, input logic [15:0] bpp,
                            input int len);
        logic [7:0] hdr [0:53];
        t_in_item   it;
        for (int i = 0; i < 54; i++) hdr[i] = 8'($urandom);
        hdr[0] = s0;
        hdr[1] = s1;
        for (int i = 0; i < 4; i++) begin
            hdr[10 + i] = off[8*i +: 8];
            hdr[18 + i] = w[8*i +: 8];
            hdr[22 + i] = h[8*i +: 8];
        end
        hdr[28] = bpp[7:0];
        hdr[29] = bpp[15:8];
        for (int i = 0; i < len; i++) begin
            it.file_byte   = (i < 54) ? hdr[i] : 8'($urandom);
            it.end_of_file = (i == len - 1);
            file_bytes_q.push_back(it);
        end
    endtask

    function automatic int frame_bytes(int w, int hm, int bpp, int off);
        int row_sz;
        row_sz = (w * (bpp / 8) + 3) & ~3;
        return off + row_sz * (hm - 1) + w * (bpp / 8);
    endfunction

    task automatic add_good_file();
        int w, hm, bpp, off, full, len, pick;
        w    = ($urandom_range(9) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
        hm   = ($urandom_range(9) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3);
        bpp  = $urandom_range(1) ? 32 : 24;
        off  = $urandom_range(1) ? 54 : 54 + $urandom_range(1, 10);
        full = frame_bytes(w, hm, bpp, off);
        pick = $urandom_range(99);
        if (pick < 15)      len = (full - 1 > off) ? $urandom_range(off + 1, full - 1) : full;
        else if (pick < 45) len = full + $urandom_range(1, 6);
        else                len = full;
        add_file(SIG_B, SIG_M, w, $urandom_range(1) ? -hm : hm, off, bpp, len);
    endtask

    task automatic add_bad_header();
        logic [31:0] w, h, off;
        logic [15:0] bpp;
        w   = $urandom_range(1, 8);
        h   = $urandom_range(1, 8);
        off = 54;
        bpp = $urandom_range(1) ? BPP_32 : BPP_24;
        case ($urandom_range(8))
            0: w   = 0;
            1: w   = 32'h8000_0000 | $urandom;
            2: h   = 0;
            3: bpp = 16'($urandom);
            4: off = $urandom_range(53);
            5: off = 32'h8000_0000 | $urandom;
            6: w   = $urandom_range(MAX_WIDTH + 1, 32'h7FFF_FFFF);
            7: h   = $urandom_range(1) ? $urandom_range(MAX_HEIGHT + 1, 20000) : 32'h8000_0000;
            default: begin
                w   = $urandom;
                h   = $urandom;
                off = $urandom;
                bpp = 16'($urandom);
            end
        endcase
        if ($urandom_range(1)) h = 32'd0 - h;
        add_file(SIG_B, SIG_M, w, h, off, bpp, 54 + $urandom_range(3));
    endtask

    task automatic add_noise();
        t_in_item it;
        int       n;
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            it.file_byte   = 8'($urandom);
            it.end_of_file = (i == n - 1);
            file_bytes_q.push_back(it);
        end
    endtask

    task automatic build_stimulus();
        int pick, off;
        // signature and short header cases
        add_file(8'h41, SIG_M, 2, 2, 54, BPP_24, 3);
        add_file(SIG_B, 8'h58, 2, 2, 54, BPP_24, 2);
        add_file(SIG_B, SIG_M, 2, 2, 54, BPP_24, 1);
        add_file(SIG_B, SIG_M, 2, 2, 54, BPP_24, 30);
        // header checks
        add_file(SIG_B, SIG_M, 0, 2, 54, BPP_24, 54);
        add_file(SIG_B, SIG_M, 32'hFFFF_FFFF, 2, 54, BPP_24, 54);
        add_file(SIG_B, SIG_M, 2, 0, 54, BPP_32, 54);
        add_file(SIG_B, SIG_M, 2, 2, 54, 16'd16, 55);
        add_file(SIG_B, SIG_M, 2, 2, 53, BPP_24, 54);
        add_file(SIG_B, SIG_M, 2, 2, 32'h8000_0036, BPP_24, 54);
        add_file(SIG_B, SIG_M, MAX_WIDTH + 1, 2, 54, BPP_24, 54);
        add_file(SIG_B, SIG_M, 2, -(MAX_HEIGHT + 1), 54, BPP_32, 54);
        // largest frame, cut off in the first row
        add_file(SIG_B, SIG_M, MAX_WIDTH, -MAX_HEIGHT, 54, BPP_32, 94);
        // end inside the offset gap, and on the last header byte
        add_file(SIG_B, SIG_M, 2, 2, 60, BPP_24, 57);
        add_file(SIG_B, SIG_M, 2, 2, 54, BPP_24, 54);
        // complete frames: single pixel, bottom-up with padding, top-down with trailer
        add_file(SIG_B, SIG_M, 1, 1, 54, BPP_24, 57);
        add_file(SIG_B, SIG_M, 3, 2, 54, BPP_24, frame_bytes(3, 2, 24, 54));
        add_file(SIG_B, SIG_M, 2, -2, 58, BPP_32, frame_bytes(2, 2, 32, 58) + 5);

        while (file_bytes_q.size() < 1750) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                add_good_file();
            end else if (pick < 73) begin
                off = 54 + $urandom_range(1, 30);
                add_file(SIG_B, SIG_M, $urandom_range(1, 4), $urandom_range(1, 4), off,
                         BPP_24, $urandom_range(54, off));
            end else if (pick < 86) begin
                add_bad_header();
            end else if (pick < 91) begin
                add_file(SIG_B, SIG_M, 1, 1, 54, BPP_24, $urandom_range(1, 53));
            end else if (pick < 96) begin
                add_file($urandom_range(1) ? SIG_B : 8'($urandom), 8'($urandom),
                         1, 1, 54, BPP_24, $urandom_range(1, 6));
            end else begin
                add_noise();
            end
        end
    endtask

    task automatic check_field(input string name, input logic [12:0] want,
                               input logic [12:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // input driver, also drives out_ready
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid  <= 1'b0;
            out_ready <= 1'b0;
        end else begin
            out_ready <= quiet || ($urandom_range(99) >= 20);
            if (!in_valid || in_fire) begin
                if (file_bytes_q.size() != 0 && (quiet || $urandom_range(99) >= 20)) begin
                    in_valid <= 1'b1;
                    in_item  <= file_bytes_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: predicts on each byte transfer, checks each result transfer
    always @(posedge i_clk) begin : monitor
        t_out_item predicted;
        t_out_item want;
        cycle_cnt <= cycle_cnt + 1;
        in_fire   <= i_rst_n && in_valid && in_ready;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                if (parse_byte(in_item, predicted)) expected_q.push_back(predicted);
            end
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %p",
                             $time, out_item);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("pixel_valid",  want.pixel_valid,  out_item.pixel_valid);
                    check_field("blue",         want.blue,         out_item.blue);
                    check_field("green",        want.green,        out_item.green);
                    check_field("red",          want.red,          out_item.red);
                    check_field("column",       want.column,       out_item.column);
                    check_field("row",          want.row,          out_item.row);
                    check_field("frame_done",   want.frame_done,   out_item.frame_done);
                    check_field("status",       want.status,       out_item.status);
                    check_field("image_width",  want.image_width,  out_item.image_width);
                    check_field("image_height", want.image_height, out_item.image_height);
                end
            end
        end
    end

    initial begin
        clear_parser();
        build_stimulus();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (file_bytes_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge i_clk);
        // keep running a while longer to catch stray results
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
